// File: rtl/stable_priority_queue_assert.svh
// Assertion macros shared by the queue RTL. Each expects clk and rst_n in scope.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stable_priority_queue: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stable_priority_queue: next-cycle check failed");

`endif

// File: rtl/spq_pkg.sv
package spq_pkg;

    localparam int DEPTH   = 8;
    localparam int TAG_W   = 32;
    localparam int PRI_W   = 8;
    localparam int OCC_W   = 4;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic
    {
        KIND_ADD    = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        kind_t            kind;
        logic [TAG_W-1:0] job_tag;
        logic [PRI_W-1:0] priority_req;
    } cmd_t;

    typedef struct packed
    {
        status_t          status;
        logic [TAG_W-1:0] out_tag;
        logic [PRI_W-1:0] out_priority;
        logic [OCC_W-1:0] occupancy;
    } res_t;

    typedef struct packed
    {
        logic [TAG_W-1:0] tag;
        logic [PRI_W-1:0] pri;
    } entry_t;

    // Broadcast to every cell of the chain.
    typedef struct packed
    {
        logic   insert;
        logic   remove;
        entry_t fresh;
    } cell_ctl_t;

endpackage

// File: rtl/spq_cell.sv
module spq_cell
(
    input  logic              clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic              occupied,
    input  logic              prev_keep,
    input  spq_pkg::entry_t   prev_entry,
    input  spq_pkg::entry_t   next_entry,
    output spq_pkg::entry_t   entry,
    output logic              keep
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // Stay in place when the new entry belongs behind this one.
    assign keep  = occupied && (entry_reg.pri <= ctl.fresh.pri);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctl.insert)
        begin
            priority if (keep)
                entry_next = entry_reg;
            else if (prev_keep)
                entry_next = ctl.fresh;
            else
                entry_next = prev_entry;
        end
        else if (ctl.remove)
        begin
            entry_next = next_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: rtl/stable_priority_queue.sv
// Channel | Handshake              | Payload
// cmd     | cmd_valid / cmd_ready  | spq_pkg::cmd_t (kind, job_tag, priority_req)
// res     | res_valid / res_ready  | spq_pkg::res_t (status, out_tag, out_priority, occupancy)
//
// One command per cycle while cmd_ready is high; its result is offered on the cycle after
// the transfer if the result register is free, else it waits in the skid slot. Every cell
// compares its priority with the new one in parallel, so an insert or a remove shifts the chain as a whole.
// Reset clears the entry count and both result slots; cell contents are left as is.
// A result register plus one skid slot let a command transfer while a result waits;
// cmd_ready drops only while both slots are full.
module stable_priority_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  spq_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output spq_pkg::res_t res
);

    `include "stable_priority_queue_assert.svh"

    localparam int CW = spq_pkg::CNT_W;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    spq_pkg::res_t      res_reg;
    spq_pkg::res_t      res_next;
    logic               res_valid_reg;
    logic               res_valid_next;
    spq_pkg::res_t      skid_reg;
    spq_pkg::res_t      skid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;

    spq_pkg::cell_ctl_t ctl;
    spq_pkg::entry_t    ent  [spq_pkg::DEPTH];
    logic               keeps[spq_pkg::DEPTH];
    spq_pkg::res_t      fresh_res;

    logic cmd_fire;
    logic res_fire;
    logic is_full;
    logic is_empty;
    logic add_on_full;
    logic remove_deep;

    assign cmd_ready = !skid_valid_reg;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign res_fire  = res_valid_reg && res_ready;
    assign is_full   = (count_reg == CW'(spq_pkg::DEPTH));
    assign is_empty  = (count_reg == '0);

    assign ctl.insert    = cmd_fire && (cmd.kind == spq_pkg::KIND_ADD) && !is_full;
    assign ctl.remove    = cmd_fire && (cmd.kind == spq_pkg::KIND_REMOVE) && !is_empty;
    assign ctl.fresh.tag = cmd.job_tag;
    assign ctl.fresh.pri = cmd.priority_req;

    assign add_on_full = cmd_fire && (cmd.kind == spq_pkg::KIND_ADD) && is_full;
    assign remove_deep = ctl.remove && (count_reg > CW'(1));

    for (genvar i = 0; i < spq_pkg::DEPTH; i++)
    begin : g_cell
        spq_pkg::entry_t prev_e;
        spq_pkg::entry_t next_e;
        logic            prev_k;

        if (i == 0)
        begin : g_head
            assign prev_e = ent[i];
            assign prev_k = 1'b1;
        end
        else
        begin : g_body
            assign prev_e = ent[i-1];
            assign prev_k = keeps[i-1];
        end

        if (i == spq_pkg::DEPTH - 1)
        begin : g_tail
            assign next_e = ent[i];
        end
        else
        begin : g_mid
            assign next_e = ent[i+1];
        end

        spq_cell u_cell
        (
            .clk        (clk),
            .ctl        (ctl),
            .occupied   (count_reg > CW'(i)),
            .prev_keep  (prev_k),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .entry      (ent[i]),
            .keep       (keeps[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.insert)
            count_next = count_reg + CW'(1);
        else if (ctl.remove)
            count_next = count_reg - CW'(1);
    end

    always_comb
    begin
        fresh_res.status       = spq_pkg::ST_DONE;
        fresh_res.out_tag      = '0;
        fresh_res.out_priority = '0;
        fresh_res.occupancy    = spq_pkg::OCC_W'(count_next);
        unique case (cmd.kind)
            spq_pkg::KIND_ADD:
            begin
                if (is_full)
                    fresh_res.status = spq_pkg::ST_FULL;
            end
            spq_pkg::KIND_REMOVE:
            begin
                if (is_empty)
                begin
                    fresh_res.status = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    fresh_res.out_tag      = ent[0].tag;
                    fresh_res.out_priority = ent[0].pri;
                end
            end
            default:
            begin
                fresh_res.status = spq_pkg::ST_DONE;
            end
        endcase
    end

    // Refill the result slot from skid first, then from a fresh transfer.
    always_comb
    begin
        res_next        = res_reg;
        res_valid_next  = res_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        priority if (res_fire || !res_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                res_next        = skid_reg;
                res_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                res_next       = fresh_res;
                res_valid_next = cmd_fire;
            end
        end
        else if (cmd_fire)
        begin
            skid_next       = fresh_res;
            skid_valid_next = 1'b1;
        end
        else
        begin
            skid_next       = skid_reg;
            skid_valid_next = skid_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            res_valid_reg  <= res_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        skid_reg <= skid_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(spq_pkg::DEPTH))
    `SPQ_ASSERT_NEXT(a_full_holds, add_on_full, count_reg == $past(count_reg))
    `SPQ_ASSERT_NOW(a_skid_only_when_held, skid_valid_reg, res_valid_reg)
    `SPQ_ASSERT_NEXT(a_head_order, remove_deep, ent[0].pri >= $past(ent[0].pri))

endmodule
